// ===== rtl/core/indexed_list_store_defines.svh =====
// Assertion macros shared by the indexed list store RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef INDEXED_LIST_STORE_DEFINES_SVH
`define INDEXED_LIST_STORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define ILS_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("indexed_list_store: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define ILS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("indexed_list_store: next-cycle check failed");

`endif

// ===== rtl/core/ils_pkg.sv =====
// Types and constants of the indexed list store.
// No dependencies; used by ils_cell and indexed_list_store.
`default_nettype none

package ils_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 6;
    localparam int LEN_W  = 7;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_DELETE_AT  = 3'd4,
        OP_INSERT_AT  = 3'd5,
        OP_DUMP       = 3'd6,
        OP_NOP        = 3'd7
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        opcode_t                   opcode;
        logic signed [DATA_W-1:0]  value;
        logic        [POS_W-1:0]   position;
    } req_t;

    typedef struct packed {
        status_t                   status;
        logic signed [DATA_W-1:0]  element;
        logic        [LEN_W-1:0]   length;
        logic                      last;
    } rsp_t;

    // Command broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_ROTATE = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [LEN_W-1:0]       pos;
        logic [LEN_W-1:0]       fill;
    } cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/indexed_list_store.sv =====
// Indexed list store: bounded ordered list of signed 32-bit elements.
// Built on ils_pkg, ils_cell and indexed_list_store_defines.svh.
//
// Usage:
//   req channel (req_valid/req_ready/req) carries one operation: push or
//   pop at either end, insert or delete at a 0-based position, or dump.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns one response per
//   operation, or one per stored element for a dump, last set on the final.
//   The list is a chain of CAPACITY cells; insert and delete shift the cells
//   from the position on; a dump rotates the chain one step per element.
// Sequencing:
//   A request is registered in S_IDLE and executed in S_EXEC once the
//   response slot is free, which loads the response register. A dump
//   then moves to S_DUMP and emits its elements one per cycle while the
//   response slot is free; no new request is taken before the previous
//   one has executed, and a dump holds the block until its last element.
//   req_ready is high only while no request is in progress.
// Reset:
//   rst_n clears the fill count and all handshake state; the list is empty.
// Stalls:
//   The response register holds until rsp_ready; execution and each dump
//   step wait for the response slot, and a new request can still be taken
//   while the last response of the previous one waits.
`default_nettype none
`include "indexed_list_store_defines.svh"

module indexed_list_store
    import ils_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  req_valid,
    output logic       req_ready,
    input  wire req_t  req,
    output logic       rsp_valid,
    input  wire logic  rsp_ready,
    output rsp_t       rsp
);

    localparam int               FILL_W  = $clog2(CAPACITY + 1);
    localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DUMP
    } state_t;

    state_t            state_reg, state_next;
    req_t              req_reg, req_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] cnt_reg, cnt_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    cell_cmd_t                cmd;
    logic signed [DATA_W-1:0] cell_data [CAPACITY];
    logic signed [DATA_W-1:0] head;

    logic             slot_free;
    logic [LEN_W-1:0] fill_len;
    logic [LEN_W-1:0] pos_len;
    logic             is_full;
    logic             is_empty;
    logic             cnt_last;

    assign head      = cell_data[0];
    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign fill_len  = LEN_W'(fill_reg);
    assign pos_len   = LEN_W'(req_reg.position);
    assign is_full   = fill_len >= CAP_LEN;
    assign is_empty  = fill_reg == '0;
    assign cnt_last  = (cnt_reg + FILL_W'(1)) == fill_reg;

    // Control: take a request, decode the held request and step the dump
    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        fill_next      = fill_reg;
        cnt_next       = cnt_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        cmd.kind       = CMD_HOLD;
        cmd.pos        = '0;
        cmd.fill       = fill_len;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (slot_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_next.status = ST_OK;
                    rsp_next.element = '0;
                    rsp_next.last   = 1'b1;
                    state_next      = S_IDLE;
                    case (req_reg.opcode)
                        OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_AT:
                        begin
                            if (is_full)
                                rsp_next.status = ST_FULL;
                            else if (req_reg.opcode == OP_INSERT_AT && pos_len > fill_len)
                                rsp_next.status = ST_RANGE;
                            else
                            begin
                                cmd.kind  = CMD_INSERT;
                                cmd.pos   = (req_reg.opcode == OP_PUSH_FRONT) ? '0 :
                                            (req_reg.opcode == OP_PUSH_BACK) ? fill_len :
                                            pos_len;
                                fill_next = fill_reg + FILL_W'(1);
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK, OP_DELETE_AT:
                        begin
                            if (is_empty)
                                rsp_next.status = ST_EMPTY;
                            else if (req_reg.opcode == OP_DELETE_AT && pos_len >= fill_len)
                                rsp_next.status = ST_RANGE;
                            else
                            begin
                                cmd.kind  = CMD_REMOVE;
                                cmd.pos   = (req_reg.opcode == OP_POP_FRONT) ? '0 :
                                            (req_reg.opcode == OP_POP_BACK) ?
                                            fill_len - LEN_W'(1) : pos_len;
                                fill_next = fill_reg - FILL_W'(1);
                            end
                        end
                        OP_DUMP:
                        begin
                            if (is_empty)
                                rsp_next.status = ST_EMPTY;
                            else
                            begin
                                rsp_valid_next = rsp_valid_reg && !rsp_ready;
                                cnt_next       = '0;
                                state_next     = S_DUMP;
                            end
                        end
                        default:
                        begin
                            rsp_next.status = ST_OK;
                        end
                    endcase
                    rsp_next.length = LEN_W'(fill_next);
                end
            end
            S_DUMP:
            begin
                // Emit the head, rotate the chain so the next element leads
                if (slot_free)
                begin
                    cmd.kind         = CMD_ROTATE;
                    rsp_valid_next   = 1'b1;
                    rsp_next.status  = ST_OK;
                    rsp_next.element = head;
                    rsp_next.length  = fill_len;
                    rsp_next.last    = cnt_last;
                    cnt_next         = cnt_reg + FILL_W'(1);
                    if (cnt_last)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            req_reg       <= '0;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            req_reg       <= req_next;
            fill_reg      <= fill_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    // Chain of element cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        ils_cell #(
            .INDEX (i)
        ) u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .new_data  (req_reg.value),
            .prev_data ((i == 0) ? req_reg.value : cell_data[(i == 0) ? 0 : i - 1]),
            .next_data ((i == CAPACITY - 1) ? head :
                        cell_data[(i == CAPACITY - 1) ? i : i + 1]),
            .head_data (head),
            .data      (cell_data[i])
        );
    end

    assign req_ready = state_reg == S_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Checks
    `ILS_ASSERT_IMPL(a_fill_bound, 1'b1, fill_len <= CAP_LEN)
    `ILS_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready)
    `ILS_ASSERT_IMPL(a_partial_only_dump, rsp_valid && !rsp.last, rsp.status == ST_OK && rsp.length != '0)
    `ILS_ASSERT_IMPL(a_dump_count, state_reg == S_DUMP, cnt_reg < fill_reg)

endmodule

`default_nettype wire

// ===== rtl/core/ils_cell.sv =====
// One storage cell of the list chain: holds one element and picks its
// next value from itself, a neighbor, the new value or the head. Uses ils_pkg.
`default_nettype none

module ils_cell
    import ils_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  wire logic                      clk,
    input  wire cell_cmd_t                 cmd,
    input  wire logic signed [DATA_W-1:0]  new_data,
    input  wire logic signed [DATA_W-1:0]  prev_data,
    input  wire logic signed [DATA_W-1:0]  next_data,
    input  wire logic signed [DATA_W-1:0]  head_data,
    output logic signed [DATA_W-1:0]       data
);

    localparam logic [LEN_W-1:0] IDX    = LEN_W'(INDEX);
    localparam logic [LEN_W-1:0] IDX_P1 = LEN_W'(INDEX + 1);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    // Select source by own position against the command's position and fill
    always_comb
    begin
        data_next = data_reg;
        case (cmd.kind)
            CMD_INSERT:
            begin
                if (IDX == cmd.pos)
                    data_next = new_data;
                else if (IDX > cmd.pos && IDX <= cmd.fill)
                    data_next = prev_data;
            end
            CMD_REMOVE:
            begin
                if (IDX >= cmd.pos && IDX_P1 < cmd.fill)
                    data_next = next_data;
            end
            CMD_ROTATE:
            begin
                if (IDX_P1 < cmd.fill)
                    data_next = next_data;
                else if (IDX_P1 == cmd.fill)
                    data_next = head_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // Element storage, undefined until written
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// ===== tb/sv/indexed_list_store_tb.sv =====
// Self-checking testbench for indexed_list_store: mirrors the list in a queue
// and checks every response. Depends on ils_pkg and the indexed_list_store RTL.
`default_nettype none

module indexed_list_store_tb;
    import ils_pkg::*;

    localparam int LIST_CAP    = 32;
    localparam int LIMIT_CYCLES = 300000;
    localparam int LONG_HOLD   = 80;

    logic  clk = 1'b0;
    logic  rst_n;
    logic  req_valid;
    logic  req_ready;
    req_t  req;
    logic  rsp_valid;
    logic  rsp_ready;
    rsp_t  rsp;

    // Shared knobs between the request driver and the response sink
    bit    no_idle;
    int    hold_request;

    // Mirror of the list plus the queue of responses it predicts
    class list_scoreboard;
        logic signed [DATA_W-1:0] mirror_cells[$];
        rsp_t                     expected_rsp[$];
        int                       errors;
        int                       requests;
        int                       checked;
        int                       full_hits;
        int                       max_fill;

        function new();
            errors    = 0;
            requests  = 0;
            checked   = 0;
            full_hits = 0;
            max_fill  = 0;
        endfunction

        // Apply one accepted request to the mirror and queue its responses
        function void note_request(req_t r);
            rsp_t want;
            int   n;
            int   pos;
            n    = mirror_cells.size();
            pos  = int'(r.position);
            want = '0;
            want.status = ST_OK;
            want.last   = 1'b1;
            requests++;
            case (r.opcode)
                OP_PUSH_FRONT, OP_PUSH_BACK:
                    if (n >= LIST_CAP)
                        want.status = ST_FULL;
                    else if (r.opcode == OP_PUSH_FRONT)
                        mirror_cells.push_front(r.value);
                    else
                        mirror_cells.push_back(r.value);
                OP_POP_FRONT, OP_POP_BACK:
                    if (n == 0)
                        want.status = ST_EMPTY;
                    else if (r.opcode == OP_POP_FRONT)
                        void'(mirror_cells.pop_front());
                    else
                        void'(mirror_cells.pop_back());
                OP_DELETE_AT:
                    if (n == 0)
                        want.status = ST_EMPTY;
                    else if (pos >= n)
                        want.status = ST_RANGE;
                    else
                        mirror_cells.delete(pos);
                OP_INSERT_AT:
                    if (n >= LIST_CAP)
                        want.status = ST_FULL;
                    else if (pos > n)
                        want.status = ST_RANGE;
                    else if (pos == n)
                        mirror_cells.push_back(r.value);
                    else
                        mirror_cells.insert(pos, r.value);
                OP_DUMP:
                    if (n == 0) begin
                        want.status = ST_EMPTY;
                    end
                    else begin
                        // one response per element, front to back
                        for (int i = 0; i < n; i++) begin
                            want.element = mirror_cells[i];
                            want.length  = LEN_W'(n);
                            want.last    = (i == n - 1);
                            expected_rsp.push_back(want);
                        end
                        return;
                    end
                default: ;
            endcase
            if (want.status == ST_FULL)
                full_hits++;
            want.length = LEN_W'(mirror_cells.size());
            if (mirror_cells.size() > max_fill)
                max_fill = mirror_cells.size();
            expected_rsp.push_back(want);
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // Compare one accepted response with the oldest expectation
        task check_response(rsp_t got);
            rsp_t want;
            if (expected_rsp.size() == 0) begin
                report_mismatch($sformatf("unexpected response status %0d element %0d length %0d",
                                          got.status, got.element, got.length));
                return;
            end
            want = expected_rsp.pop_front();
            checked++;
            if (got.status !== want.status || got.element !== want.element ||
                got.length !== want.length || got.last !== want.last)
                report_mismatch($sformatf(
                    "rsp %0d got st %0d el %0d len %0d last %0b, want st %0d el %0d len %0d last %0b",
                    checked, got.status, got.element, got.length, got.last,
                    want.status, want.element, want.length, want.last));
        endtask
    endclass

    list_scoreboard model;

    indexed_list_store #(
        .CAPACITY (LIST_CAP)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Offer one request after a gap, hold it until taken, then mirror it
    task automatic send_req(input req_t r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        repeat (gap)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (!req_ready);
        model.note_request(r);
    endtask

    task automatic send_op(input opcode_t op, input logic signed [DATA_W-1:0] v,
                           input logic [POS_W-1:0] p);
        req_t r;
        r.opcode   = op;
        r.value    = v;
        r.position = p;
        send_req(r);
    endtask

    task automatic wait_drained();
        while (model.expected_rsp.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly legal positions, now and then anything in the field
    function automatic logic [POS_W-1:0] pick_pos(input int hi);
        if (hi < 0 || $urandom_range(0, 9) == 0)
            return POS_W'($urandom_range(0, 63));
        return POS_W'($urandom_range(0, hi));
    endfunction

    // mode 0: mixed, 1: growing, 2: shrinking
    function automatic req_t random_request(input int mode);
        req_t r;
        int   n;
        int   roll;
        n    = model.mirror_cells.size();
        roll = $urandom_range(0, 99);
        r.value = pick_value();
        if (mode == 1)
            r.opcode = (roll < 30) ? OP_PUSH_FRONT : (roll < 60) ? OP_PUSH_BACK : OP_INSERT_AT;
        else if (mode == 2)
            r.opcode = (roll < 25) ? OP_POP_FRONT : (roll < 50) ? OP_POP_BACK : OP_DELETE_AT;
        else if (roll < 18) r.opcode = OP_PUSH_FRONT;
        else if (roll < 36) r.opcode = OP_PUSH_BACK;
        else if (roll < 46) r.opcode = OP_POP_FRONT;
        else if (roll < 56) r.opcode = OP_POP_BACK;
        else if (roll < 72) r.opcode = OP_DELETE_AT;
        else if (roll < 90) r.opcode = OP_INSERT_AT;
        else if (roll < 97) r.opcode = OP_DUMP;
        else                r.opcode = OP_NOP;
        if (r.opcode == OP_INSERT_AT)
            r.position = pick_pos(mode == 1 ? n : n + 1);
        else
            r.position = pick_pos(n - 1);
        return r;
    endfunction

    // Response sink: random stalls, plus one long hold-off on request
    initial
    begin
        int stall;
        int held;
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request > 0)
            begin
                held = 0;
                while (held < hold_request)
                begin
                    @(negedge clk);
                    rsp_ready <= 1'b0;
                    held++;
                end
                hold_request = 0;
            end
            stall = no_idle ? 0 : $urandom_range(0, 6);
            repeat (stall)
            begin
                @(negedge clk);
                rsp_ready <= 1'b0;
            end
            @(negedge clk);
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!rsp_valid);
            model.check_response(rsp);
        end
    end

    // Run limit
    initial
    begin
        #(LIMIT_CYCLES * 20);
        $display("Timeout after %0d cycles, %0d responses still expected",
                 LIMIT_CYCLES, model.expected_rsp.size());
        $display("indexed_list_store_tb: FAIL");
        $finish;
    end

    // Main sequence
    initial
    begin
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        no_idle      = 1'b0;
        hold_request = 0;
        model        = new();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty list, extremes, edge positions, bad positions
        send_op(OP_DUMP,       32'sd5, 6'd0);
        send_op(OP_POP_FRONT,  32'sd0, 6'd0);
        send_op(OP_POP_BACK,   32'sd0, 6'd0);
        send_op(OP_DELETE_AT,  32'sd0, 6'd0);
        send_op(OP_INSERT_AT,  32'sd7, 6'd1);
        send_op(OP_INSERT_AT,  32'sd11, 6'd0);
        send_op(OP_PUSH_FRONT, 32'sh8000_0000, 6'd0);
        send_op(OP_PUSH_BACK,  32'sh7fff_ffff, 6'd0);
        send_op(OP_PUSH_BACK,  32'sd0, 6'd63);
        send_op(OP_PUSH_FRONT, -32'sd1, 6'd0);
        send_op(OP_INSERT_AT,  32'sh5a5a_a5a5, 6'd5);
        send_op(OP_INSERT_AT,  32'sh1234_5678, 6'd2);
        send_op(OP_INSERT_AT,  32'sd3, 6'd7);
        send_op(OP_DELETE_AT,  32'sd0, 6'd6);
        send_op(OP_DELETE_AT,  32'sd0, 6'd63);
        send_op(OP_INSERT_AT,  32'sd9, 6'd63);
        send_op(OP_NOP,        32'sd1, 6'd2);
        send_op(OP_DUMP,       32'sd0, 6'd0);
        send_op(OP_DELETE_AT,  32'sd0, 6'd1);
        send_op(OP_DELETE_AT,  32'sd0, 6'd4);
        send_op(OP_POP_FRONT,  32'sd0, 6'd0);
        send_op(OP_POP_BACK,   32'sd0, 6'd0);
        send_op(OP_DUMP,       32'sd0, 6'd0);
        @(negedge clk);
        req_valid <= 1'b0;
        wait_drained();

        // Mixed random traffic
        repeat (15) send_req(random_request(0));

        // Long hold-off at the sink while requests keep coming back to back
        hold_request = LONG_HOLD;
        no_idle      = 1'b1;
        repeat (10) send_req(random_request(0));
        no_idle      = 1'b0;
        @(negedge clk);
        req_valid <= 1'b0;
        wait_drained();

        // Fill to capacity without idling, then push against a full list
        no_idle = 1'b1;
        while (model.mirror_cells.size() < LIST_CAP)
            send_req(random_request(1));
        no_idle = 1'b0;
        send_op(OP_PUSH_FRONT, pick_value(), 6'd0);
        send_op(OP_PUSH_BACK,  pick_value(), 6'd0);
        send_op(OP_INSERT_AT,  pick_value(), 6'd3);
        send_op(OP_DUMP,       32'sd0, 6'd0);

        repeat (8) send_req(random_request(0));

        // Drain to empty, then poke the empty list
        while (model.mirror_cells.size() > 0)
            send_req(random_request(2));
        send_op(OP_POP_BACK, 32'sd0, 6'd0);
        send_op(OP_DUMP,     32'sd0, 6'd0);
        repeat (5) send_req(random_request(0));

        @(negedge clk);
        req_valid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge clk);

        $display("Run covered %0d requests and %0d checked responses; peak length %0d,",
                 model.requests, model.checked, model.max_fill);
        $display("full-list rejects %0d, mismatches %0d", model.full_hits, model.errors);
        if (model.errors == 0 && model.expected_rsp.size() == 0)
            $display("indexed_list_store_tb: PASS");
        else
            $display("indexed_list_store_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
